### rtl/core/esc_pkg.sv
// Shared types, constants and the microcode store of the sensor compensation block.
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

   localparam logic [23:0] SKIP24  = 24'h800000;
   localparam logic [15:0] SKIP16  = 16'h8000;
   localparam logic [31:0] HUM_MAX = 32'd419430400;
   localparam int unsigned PC_W    = 7;
   localparam int unsigned XW      = 64;

   typedef enum logic [2:0] {
      CSR_TEMP = 3'd0,
      CSR_PLO  = 3'd1,
      CSR_PHI  = 3'd2,
      CSR_P9H  = 3'd3,
      CSR_HUM  = 3'd4
   } csr_type;

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_ADDI, OP_LDI, OP_SHL, OP_ASR, OP_ASR32,
      OP_MUL, OP_DIV, OP_FSET, OP_TSTORE, OP_PSTORE, OP_HSTORE, OP_END
   } op_type;

   typedef enum logic [4:0] {
      S_W0, S_W1, S_W2, S_W3, S_W4, S_W5, S_W6, S_W7,
      S_ADCT, S_ADCP, S_RH,
      S_T1, S_T2, S_T3,
      S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
      S_H1, S_H2, S_H3, S_H4, S_H5, S_H6,
      S_FINE
   } src_type;

   typedef struct packed {
      op_type             op;
      logic [2:0]         dst;
      src_type            a;
      src_type            b;
      logic [5:0]         sh;
      logic signed [31:0] imm;
   } uop_type;

   typedef struct packed {
      logic start;
      logic div;
   } md_req_type;

   typedef struct packed {
      logic          done;
      logic          divz;
      logic [XW-1:0] result;
   } md_rsp_type;

   function automatic uop_type mk(op_type op, logic [2:0] dst, src_type a, src_type b,
                                  logic [5:0] sh, logic signed [31:0] imm);
      uop_type u;
      u.op  = op;
      u.dst = dst;
      u.a   = a;
      u.b   = b;
      u.sh  = sh;
      u.imm = imm;
      return u;
   endfunction

   function automatic uop_type ucode(logic [PC_W-1:0] pc);
      uop_type u;
      unique case (pc)
         // temperature
         7'd0:  u = mk(OP_ASR,    3'd0, S_ADCT, S_W0, 6'd3,  32'sd0);
         7'd1:  u = mk(OP_SHL,    3'd1, S_T1,   S_W0, 6'd1,  32'sd0);
         7'd2:  u = mk(OP_SUB,    3'd0, S_W0,   S_W1, 6'd0,  32'sd0);
         7'd3:  u = mk(OP_MUL,    3'd0, S_W0,   S_T2, 6'd0,  32'sd0);
         7'd4:  u = mk(OP_ASR32,  3'd0, S_W0,   S_W0, 6'd11, 32'sd0);
         7'd5:  u = mk(OP_ASR,    3'd1, S_ADCT, S_W0, 6'd4,  32'sd0);
         7'd6:  u = mk(OP_SUB,    3'd1, S_W1,   S_T1, 6'd0,  32'sd0);
         7'd7:  u = mk(OP_MUL,    3'd1, S_W1,   S_W1, 6'd0,  32'sd0);
         7'd8:  u = mk(OP_ASR32,  3'd1, S_W1,   S_W0, 6'd12, 32'sd0);
         7'd9:  u = mk(OP_MUL,    3'd1, S_W1,   S_T3, 6'd0,  32'sd0);
         7'd10: u = mk(OP_ASR32,  3'd1, S_W1,   S_W0, 6'd14, 32'sd0);
         7'd11: u = mk(OP_ADD,    3'd0, S_W0,   S_W1, 6'd0,  32'sd0);
         7'd12: u = mk(OP_FSET,   3'd0, S_W0,   S_W0, 6'd0,  32'sd0);
         7'd13: u = mk(OP_LDI,    3'd1, S_W0,   S_W0, 6'd0,  32'sd5);
         7'd14: u = mk(OP_MUL,    3'd0, S_FINE, S_W1, 6'd0,  32'sd0);
         7'd15: u = mk(OP_ADDI,   3'd0, S_W0,   S_W0, 6'd0,  32'sd128);
         7'd16: u = mk(OP_ASR32,  3'd0, S_W0,   S_W0, 6'd8,  32'sd0);
         7'd17: u = mk(OP_TSTORE, 3'd0, S_W0,   S_W0, 6'd0,  32'sd0);
         // pressure
         7'd18: u = mk(OP_ADDI,   3'd0, S_FINE, S_W0, 6'd0,  -32'sd128000);
         7'd19: u = mk(OP_MUL,    3'd1, S_W0,   S_W0, 6'd0,  32'sd0);
         7'd20: u = mk(OP_MUL,    3'd2, S_W1,   S_P6, 6'd0,  32'sd0);
         7'd21: u = mk(OP_MUL,    3'd3, S_W0,   S_P5, 6'd0,  32'sd0);
         7'd22: u = mk(OP_SHL,    3'd3, S_W3,   S_W0, 6'd17, 32'sd0);
         7'd23: u = mk(OP_ADD,    3'd2, S_W2,   S_W3, 6'd0,  32'sd0);
         7'd24: u = mk(OP_SHL,    3'd3, S_P4,   S_W0, 6'd35, 32'sd0);
         7'd25: u = mk(OP_ADD,    3'd2, S_W2,   S_W3, 6'd0,  32'sd0);
         7'd26: u = mk(OP_MUL,    3'd1, S_W1,   S_P3, 6'd0,  32'sd0);
         7'd27: u = mk(OP_ASR,    3'd1, S_W1,   S_W0, 6'd8,  32'sd0);
         7'd28: u = mk(OP_MUL,    3'd3, S_W0,   S_P2, 6'd0,  32'sd0);
         7'd29: u = mk(OP_SHL,    3'd3, S_W3,   S_W0, 6'd12, 32'sd0);
         7'd30: u = mk(OP_ADD,    3'd1, S_W1,   S_W3, 6'd0,  32'sd0);
         7'd31: u = mk(OP_LDI,    3'd3, S_W0,   S_W0, 6'd0,  32'sd1);
         7'd32: u = mk(OP_SHL,    3'd3, S_W3,   S_W0, 6'd47, 32'sd0);
         7'd33: u = mk(OP_ADD,    3'd1, S_W1,   S_W3, 6'd0,  32'sd0);
         7'd34: u = mk(OP_MUL,    3'd1, S_W1,   S_P1, 6'd0,  32'sd0);
         7'd35: u = mk(OP_ASR,    3'd1, S_W1,   S_W0, 6'd33, 32'sd0);
         7'd36: u = mk(OP_LDI,    3'd3, S_W0,   S_W0, 6'd0,  32'sd1048576);
         7'd37: u = mk(OP_SUB,    3'd3, S_W3,   S_ADCP, 6'd0, 32'sd0);
         7'd38: u = mk(OP_SHL,    3'd3, S_W3,   S_W0, 6'd31, 32'sd0);
         7'd39: u = mk(OP_SUB,    3'd3, S_W3,   S_W2, 6'd0,  32'sd0);
         7'd40: u = mk(OP_LDI,    3'd4, S_W0,   S_W0, 6'd0,  32'sd3125);
         7'd41: u = mk(OP_MUL,    3'd3, S_W3,   S_W4, 6'd0,  32'sd0);
         7'd42: u = mk(OP_DIV,    3'd3, S_W3,   S_W1, 6'd0,  32'sd0);
         7'd43: u = mk(OP_ASR,    3'd4, S_W3,   S_W0, 6'd13, 32'sd0);
         7'd44: u = mk(OP_MUL,    3'd5, S_P9,   S_W4, 6'd0,  32'sd0);
         7'd45: u = mk(OP_MUL,    3'd5, S_W5,   S_W4, 6'd0,  32'sd0);
         7'd46: u = mk(OP_ASR,    3'd5, S_W5,   S_W0, 6'd25, 32'sd0);
         7'd47: u = mk(OP_MUL,    3'd6, S_P8,   S_W3, 6'd0,  32'sd0);
         7'd48: u = mk(OP_ASR,    3'd6, S_W6,   S_W0, 6'd19, 32'sd0);
         7'd49: u = mk(OP_ADD,    3'd3, S_W3,   S_W5, 6'd0,  32'sd0);
         7'd50: u = mk(OP_ADD,    3'd3, S_W3,   S_W6, 6'd0,  32'sd0);
         7'd51: u = mk(OP_ASR,    3'd3, S_W3,   S_W0, 6'd8,  32'sd0);
         7'd52: u = mk(OP_SHL,    3'd4, S_P7,   S_W0, 6'd4,  32'sd0);
         7'd53: u = mk(OP_ADD,    3'd3, S_W3,   S_W4, 6'd0,  32'sd0);
         7'd54: u = mk(OP_PSTORE, 3'd0, S_W3,   S_W0, 6'd0,  32'sd0);
         // humidity
         7'd55: u = mk(OP_ADDI,   3'd0, S_FINE, S_W0, 6'd0,  -32'sd76800);
         7'd56: u = mk(OP_SHL,    3'd1, S_RH,   S_W0, 6'd14, 32'sd0);
         7'd57: u = mk(OP_SHL,    3'd2, S_H4,   S_W0, 6'd20, 32'sd0);
         7'd58: u = mk(OP_SUB,    3'd1, S_W1,   S_W2, 6'd0,  32'sd0);
         7'd59: u = mk(OP_MUL,    3'd2, S_H5,   S_W0, 6'd0,  32'sd0);
         7'd60: u = mk(OP_SUB,    3'd1, S_W1,   S_W2, 6'd0,  32'sd0);
         7'd61: u = mk(OP_ADDI,   3'd1, S_W1,   S_W0, 6'd0,  32'sd16384);
         7'd62: u = mk(OP_ASR32,  3'd1, S_W1,   S_W0, 6'd15, 32'sd0);
         7'd63: u = mk(OP_MUL,    3'd2, S_W0,   S_H6, 6'd0,  32'sd0);
         7'd64: u = mk(OP_ASR32,  3'd2, S_W2,   S_W0, 6'd10, 32'sd0);
         7'd65: u = mk(OP_MUL,    3'd3, S_W0,   S_H3, 6'd0,  32'sd0);
         7'd66: u = mk(OP_ASR32,  3'd3, S_W3,   S_W0, 6'd11, 32'sd0);
         7'd67: u = mk(OP_ADDI,   3'd3, S_W3,   S_W0, 6'd0,  32'sd32768);
         7'd68: u = mk(OP_MUL,    3'd2, S_W2,   S_W3, 6'd0,  32'sd0);
         7'd69: u = mk(OP_ASR32,  3'd2, S_W2,   S_W0, 6'd10, 32'sd0);
         7'd70: u = mk(OP_ADDI,   3'd2, S_W2,   S_W0, 6'd0,  32'sd2097152);
         7'd71: u = mk(OP_MUL,    3'd2, S_W2,   S_H2, 6'd0,  32'sd0);
         7'd72: u = mk(OP_ADDI,   3'd2, S_W2,   S_W0, 6'd0,  32'sd8192);
         7'd73: u = mk(OP_ASR32,  3'd2, S_W2,   S_W0, 6'd14, 32'sd0);
         7'd74: u = mk(OP_MUL,    3'd1, S_W1,   S_W2, 6'd0,  32'sd0);
         7'd75: u = mk(OP_ASR32,  3'd2, S_W1,   S_W0, 6'd15, 32'sd0);
         7'd76: u = mk(OP_MUL,    3'd2, S_W2,   S_W2, 6'd0,  32'sd0);
         7'd77: u = mk(OP_ASR32,  3'd2, S_W2,   S_W0, 6'd7,  32'sd0);
         7'd78: u = mk(OP_MUL,    3'd2, S_W2,   S_H1, 6'd0,  32'sd0);
         7'd79: u = mk(OP_ASR32,  3'd2, S_W2,   S_W0, 6'd4,  32'sd0);
         7'd80: u = mk(OP_SUB,    3'd1, S_W1,   S_W2, 6'd0,  32'sd0);
         7'd81: u = mk(OP_HSTORE, 3'd0, S_W1,   S_W0, 6'd0,  32'sd0);
         default: u = mk(OP_END,  3'd0, S_W0,   S_W0, 6'd0,  32'sd0);
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

### rtl/core/esc_if.sv
// Request and response channel interfaces of the sensor compensation block.
`timescale 1ns / 1ps
`default_nettype none
interface esc_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] raw_temp;
   logic [23:0] raw_press;
   logic [15:0] raw_hum;
   modport source (output valid, raw_temp, raw_press, raw_hum, input ready);
   modport sink   (input valid, raw_temp, raw_press, raw_hum, output ready);
endinterface

interface esc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temp_centi;
   logic               temp_ok;
   logic [31:0]        press_q24_8;
   logic               press_ok;
   logic [16:0]        hum_q22_10;
   logic               hum_ok;
   modport source (output valid, temp_centi, temp_ok, press_q24_8, press_ok, hum_q22_10,
                   hum_ok, input ready);
   modport sink   (input valid, temp_centi, temp_ok, press_q24_8, press_ok, hum_q22_10,
                   hum_ok, output ready);
endinterface
`default_nettype wire

### rtl/core/esc_muldiv.sv
// Shared 64-bit multiplier (4 bits per cycle) and signed restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module esc_muldiv (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire esc_pkg::md_req_type      md_req,
   input  wire logic [esc_pkg::XW-1:0]   opa,
   input  wire logic [esc_pkg::XW-1:0]   opb,
   output esc_pkg::md_rsp_type           md_rsp
);

   typedef enum logic [3:0] {
      MD_IDLE = 4'b0001,
      MD_MUL  = 4'b0010,
      MD_DIV  = 4'b0100,
      MD_FIN  = 4'b1000
   } md_state_type;

   md_state_type         state_ff, state_in;
   logic [63:0]          acc_ff, acc_in;
   logic [63:0]          x_ff, x_in;
   logic [63:0]          y_ff, y_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 div_ff, div_in;
   logic                 neg_ff, neg_in;
   logic                 divz_ff, divz_in;
   logic [63:0]          pp;
   logic [64:0]          rem_sh;
   logic [64:0]          diff;

   always_comb begin
      pp = 64'd0;
      for (int i = 0; i < 4; i++) begin
         if (y_ff[i]) pp = pp + (x_ff << i);
      end
      rem_sh = {acc_ff, y_ff[63]};
      diff   = rem_sh - {1'b0, x_ff};
   end

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      cnt_in   = cnt_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      divz_in  = divz_ff;
      unique case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               cnt_in  = 6'd0;
               div_in  = md_req.div;
               acc_in  = 64'd0;
               if (md_req.div) begin
                  x_in     = opb[63] ? (64'd0 - opb) : opb;
                  y_in     = opa[63] ? (64'd0 - opa) : opa;
                  neg_in   = opa[63] ^ opb[63];
                  divz_in  = (opb == 64'd0);
                  state_in = MD_DIV;
               end else begin
                  x_in     = opa;
                  y_in     = opb;
                  state_in = MD_MUL;
               end
            end
         end
         MD_MUL: begin
            acc_in = acc_ff + pp;
            x_in   = x_ff << 4;
            y_in   = y_ff >> 4;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd15) state_in = MD_FIN;
         end
         MD_DIV: begin
            if (!diff[64]) begin
               acc_in = diff[63:0];
               y_in   = {y_ff[62:0], 1'b1};
            end else begin
               acc_in = rem_sh[63:0];
               y_in   = {y_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = MD_FIN;
         end
         MD_FIN: begin
            state_in = MD_IDLE;
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      cnt_ff  <= cnt_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      divz_ff <= divz_in;
   end

   always_comb begin
      md_rsp.done = (state_ff == MD_FIN);
      md_rsp.divz = div_ff & divz_ff;
      if (!div_ff)      md_rsp.result = acc_ff;
      else if (divz_ff) md_rsp.result = 64'd0;
      else if (neg_ff)  md_rsp.result = 64'd0 - y_ff;
      else              md_rsp.result = y_ff;
   end

endmodule
`default_nettype wire

### rtl/core/env_sensor_compensation.sv
// Top level: microcoded sequencer for integer temperature, pressure and humidity compensation.
`timescale 1ns / 1ps
`default_nettype none
// One beat of raw readings is taken when the block is idle and compensated by a small
// microcode sequencer driving one shared 64-bit multiply/divide unit. An item runs 22
// multiplies on the 4-bit-per-cycle multiplier, one signed division, and 60 other
// micro-ops. req ready is low from acceptance until the result beat is taken. Coefficients
// are written through the csr port; the user must write them only while idle, as the block
// itself does not enforce it. Fine temperature is kept across items.
module env_sensor_compensation (
   input  wire logic        clock,
   input  wire logic        reset,
   esc_req_if.sink          req_bus,
   esc_rsp_if.source        rsp_bus,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_WAIT  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [esc_pkg::PC_W-1:0]   pc_ff, pc_in;
   logic [47:0]                tc_ff;
   logic [63:0]                plo_ff, phi_ff;
   logic [47:0]                p9h_ff;
   logic [39:0]                hc_ff;
   logic [23:0]                rt_ff, rp_ff;
   logic [15:0]                rh_ff;
   logic                       tok_ff, pok_ff, hok_ff, divz_ff;
   logic [31:0]                fine_ff;
   logic [31:0]                tcenti_ff, press_ff;
   logic [16:0]                hum_ff;
   logic [63:0]                wreg [8];
   logic [63:0]                opa_ff, opb_ff;
   logic                       wr_en;
   logic [63:0]                wr_data;
   logic [63:0]                alu_res;
   logic signed [31:0]         asr32_val;
   logic [31:0]                hv;
   logic [31:0]                hclamp;
   esc_pkg::uop_type           uop;
   esc_pkg::md_req_type        md_req;
   esc_pkg::md_rsp_type        md_rsp;

   assign uop = esc_pkg::ucode(pc_ff);

   function automatic logic [63:0] sx16(logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] operand(esc_pkg::src_type s);
      logic [63:0] r;
      unique case (s)
         esc_pkg::S_W0, esc_pkg::S_W1, esc_pkg::S_W2, esc_pkg::S_W3,
         esc_pkg::S_W4, esc_pkg::S_W5, esc_pkg::S_W6,
         esc_pkg::S_W7: r = wreg[s[2:0]];
         esc_pkg::S_ADCT: r = {44'd0, rt_ff[23:4]};
         esc_pkg::S_ADCP: r = {44'd0, rp_ff[23:4]};
         esc_pkg::S_RH:   r = {48'd0, rh_ff};
         esc_pkg::S_T1:   r = {48'd0, tc_ff[15:0]};
         esc_pkg::S_T2:   r = sx16(tc_ff[31:16]);
         esc_pkg::S_T3:   r = sx16(tc_ff[47:32]);
         esc_pkg::S_P1:   r = {48'd0, plo_ff[15:0]};
         esc_pkg::S_P2:   r = sx16(plo_ff[31:16]);
         esc_pkg::S_P3:   r = sx16(plo_ff[47:32]);
         esc_pkg::S_P4:   r = sx16(plo_ff[63:48]);
         esc_pkg::S_P5:   r = sx16(phi_ff[15:0]);
         esc_pkg::S_P6:   r = sx16(phi_ff[31:16]);
         esc_pkg::S_P7:   r = sx16(phi_ff[47:32]);
         esc_pkg::S_P8:   r = sx16(phi_ff[63:48]);
         esc_pkg::S_P9:   r = sx16(p9h_ff[15:0]);
         esc_pkg::S_H1:   r = {56'd0, p9h_ff[23:16]};
         esc_pkg::S_H2:   r = sx16(p9h_ff[39:24]);
         esc_pkg::S_H3:   r = {56'd0, p9h_ff[47:40]};
         esc_pkg::S_H4:   r = sx16(hc_ff[15:0]);
         esc_pkg::S_H5:   r = sx16(hc_ff[31:16]);
         esc_pkg::S_H6:   r = {{56{hc_ff[39]}}, hc_ff[39:32]};
         esc_pkg::S_FINE: r = {{32{fine_ff[31]}}, fine_ff};
         default:         r = 64'd0;
      endcase
      return r;
   endfunction

   always_comb begin
      asr32_val = $signed(opa_ff[31:0]) >>> uop.sh;
      case (uop.op)
         esc_pkg::OP_ADD:   alu_res = opa_ff + opb_ff;
         esc_pkg::OP_SUB:   alu_res = opa_ff - opb_ff;
         esc_pkg::OP_ADDI:  alu_res = opa_ff + {{32{uop.imm[31]}}, uop.imm};
         esc_pkg::OP_LDI:   alu_res = {{32{uop.imm[31]}}, uop.imm};
         esc_pkg::OP_SHL:   alu_res = opa_ff << uop.sh;
         esc_pkg::OP_ASR:   alu_res = $signed(opa_ff) >>> uop.sh;
         esc_pkg::OP_ASR32: alu_res = {{32{asr32_val[31]}}, asr32_val};
         default:           alu_res = md_rsp.result;
      endcase
      hv = opa_ff[31:0];
      if (hv[31])               hclamp = 32'd0;
      else if (hv > esc_pkg::HUM_MAX) hclamp = esc_pkg::HUM_MAX;
      else                      hclamp = hv;
   end

   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      wr_en         = 1'b0;
      wr_data       = alu_res;
      md_req.start  = 1'b0;
      md_req.div    = (uop.op == esc_pkg::OP_DIV);
      unique case (state_ff)
         ST_IDLE: begin
            pc_in = '0;
            if (req_bus.valid) state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_EXEC;
         ST_EXEC: begin
            case (uop.op)
               esc_pkg::OP_MUL, esc_pkg::OP_DIV: begin
                  md_req.start = 1'b1;
                  state_in     = ST_WAIT;
               end
               esc_pkg::OP_END: state_in = ST_DONE;
               esc_pkg::OP_FSET, esc_pkg::OP_TSTORE, esc_pkg::OP_PSTORE,
               esc_pkg::OP_HSTORE: begin
                  pc_in    = pc_ff + 1'b1;
                  state_in = ST_FETCH;
               end
               default: begin
                  wr_en    = 1'b1;
                  pc_in    = pc_ff + 1'b1;
                  state_in = ST_FETCH;
               end
            endcase
         end
         ST_WAIT: begin
            if (md_rsp.done) begin
               wr_en    = 1'b1;
               wr_data  = md_rsp.result;
               pc_in    = pc_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (rsp_bus.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         fine_ff  <= 32'd0;
         tc_ff    <= 48'd0;
         plo_ff   <= 64'd0;
         phi_ff   <= 64'd0;
         p9h_ff   <= 48'd0;
         hc_ff    <= 40'd0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         if (state_ff == ST_EXEC && uop.op == esc_pkg::OP_FSET && tok_ff) begin
            fine_ff <= opa_ff[31:0];
         end
         if (csr_we) begin
            unique case (esc_pkg::csr_type'(csr_index))
               esc_pkg::CSR_TEMP: tc_ff  <= csr_wdata[47:0];
               esc_pkg::CSR_PLO:  plo_ff <= csr_wdata;
               esc_pkg::CSR_PHI:  phi_ff <= csr_wdata;
               esc_pkg::CSR_P9H:  p9h_ff <= csr_wdata[47:0];
               esc_pkg::CSR_HUM:  hc_ff  <= csr_wdata[39:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_bus.valid) begin
         rt_ff  <= req_bus.raw_temp;
         rp_ff  <= req_bus.raw_press;
         rh_ff  <= req_bus.raw_hum;
         tok_ff <= (req_bus.raw_temp != esc_pkg::SKIP24);
         pok_ff <= (req_bus.raw_press != esc_pkg::SKIP24);
         hok_ff <= (req_bus.raw_hum != esc_pkg::SKIP16);
      end
      if (state_ff == ST_FETCH) begin
         opa_ff <= operand(uop.a);
         opb_ff <= operand(uop.b);
      end
      if (wr_en) wreg[uop.dst] <= wr_data;
      if (state_ff == ST_WAIT && md_rsp.done && md_req.div) divz_ff <= md_rsp.divz;
      if (state_ff == ST_EXEC) begin
         if (uop.op == esc_pkg::OP_TSTORE) tcenti_ff <= tok_ff ? opa_ff[31:0] : 32'd0;
         if (uop.op == esc_pkg::OP_PSTORE) begin
            press_ff <= (pok_ff && !divz_ff) ? opa_ff[31:0] : 32'd0;
         end
         if (uop.op == esc_pkg::OP_HSTORE) hum_ff <= hok_ff ? hclamp[28:12] : 17'd0;
      end
   end

   esc_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .opa    (opa_ff),
      .opb    (opb_ff),
      .md_rsp (md_rsp)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = (state_ff == ST_DONE);
   assign rsp_bus.temp_centi  = tcenti_ff;
   assign rsp_bus.temp_ok     = tok_ff;
   assign rsp_bus.press_q24_8 = press_ff;
   assign rsp_bus.press_ok    = pok_ff;
   assign rsp_bus.hum_q22_10  = hum_ff;
   assign rsp_bus.hum_ok      = hok_ff;

endmodule
`default_nettype wire

### rtl/core/esc_checker.sv
// Port-level checker for the sensor compensation block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module esc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] temp_centi,
   input wire logic        temp_ok,
   input wire logic [16:0] hum_q22_10,
   input wire logic        hum_ok
);

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while a beat is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(temp_centi) && $stable(hum_q22_10))
      else $error("rsp beat dropped or changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input taken while a result is pending");

   a_temp_skip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !temp_ok |-> temp_centi == 32'd0)
      else $error("skipped temperature gives nonzero value");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && hum_ok |-> hum_q22_10 <= 17'd102400)
      else $error("humidity out of range");

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .temp_centi (rsp_bus.temp_centi),
   .temp_ok    (rsp_bus.temp_ok),
   .hum_q22_10 (rsp_bus.hum_q22_10),
   .hum_ok     (rsp_bus.hum_ok)
);
`default_nettype wire
